### design/kmrr_pkg.sv
// kmrr_pkg: shared codes and field widths for the key macro record/replay core
// operation kinds, macro modes and result status codes
// no dependencies
package kmrr_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ModeW   = 2;

  // operation kinds carried in the input tuser
  localparam logic [KindW-1:0] KIND_START_REC = 3'd0;
  localparam logic [KindW-1:0] KIND_END_REC   = 3'd1;
  localparam logic [KindW-1:0] KIND_EXECUTE   = 3'd2;
  localparam logic [KindW-1:0] KIND_ABORT     = 3'd3;
  localparam logic [KindW-1:0] KIND_GET_KEY   = 3'd4;
  localparam logic [KindW-1:0] KIND_QUERY     = 3'd5;

  // macro modes
  localparam logic [ModeW-1:0] MODE_IDLE      = 2'd0;
  localparam logic [ModeW-1:0] MODE_RECORDING = 2'd1;
  localparam logic [ModeW-1:0] MODE_REPLAYING = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_IGNORED  = 3'd1;
  localparam logic [StatusW-1:0] ST_NO_MACRO = 3'd2;
  localparam logic [StatusW-1:0] ST_IN_MACRO = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd4;

  // input tdata: user_key, repeat_count; output tdata: see top level
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  // result fields waiting for the store read in the second stage
  typedef struct packed {
    logic               sel_mem;
    logic [KeyW-1:0]    key;
    logic               key_valid;
    logic               key_used;
    logic               pending;
    logic               recording;
    logic               replaying;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

### design/key_macro_record_replay_core.sv
// key_macro_record_replay_core: records key codes into an on-chip store and
// replays them a requested number of times
// depends on kmrr_pkg
//
// usage:
//   input stream s_axis: one operation per transfer. tuser holds the kind
//   (start record, end record, execute, abort, get key, query pending),
//   tdata holds the user key and the repeat count.
//   output stream m_axis: exactly one result per input transfer, in order.
//   throughput: one item per cycle while the output is not stalled; the
//   control registers are updated at the input transfer and the key store
//   takes one write (recording) or one read (replaying) per item, so items
//   never collide on an entry. the replayed key comes from the synchronous
//   store read, which the middle stage waits for.
//   reset: mode goes idle, no macro is defined and all counters clear. the
//   store holds no valid data and needs no clearing pass; only entries
//   below the recorded length are ever read.
//   stall: when m_axis_tready_i is low the output and the middle stage
//   hold, and s_axis_tready_o drops once both are full.
module key_macro_record_replay_core
  import kmrr_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [7:0] user_key, [23:8] repeat_count
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [2:0] kind
  input  logic [KindW-1:0]    s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] key_out, [8] key_valid, [9] user_key_used, [10] pending,
  // [11] recording, [12] replaying, [15:13] status
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LenW  = $clog2(STORE_DEPTH + 1);
  localparam logic [LenW-1:0] DepthVal = LenW'(STORE_DEPTH);

  logic [ModeW-1:0]  mode_q, mode_d;
  logic              defined_q, defined_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] rep_q, rep_d;

  logic [KindW-1:0]  kind;
  logic [KeyW-1:0]   ukey;
  logic [CountW-1:0] count;

  logic              in_xfer;
  logic              wr_en, rd_en;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [KeyW-1:0]   mem_q [STORE_DEPTH];
  logic [KeyW-1:0]   rd_data_q;

  res_t              res_d, s1_q;
  logic              s1_valid_q, s1_adv;
  logic              m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [KeyW-1:0]   s1_key;

  assign kind  = s_axis_tuser_i;
  assign ukey  = s_axis_tdata_i[KeyW-1:0];
  assign count = s_axis_tdata_i[KeyW +: CountW];

  assign s1_adv          = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // next control state and result fields for the item on the input
  always_comb begin
    mode_d    = mode_q;
    defined_d = defined_q;
    len_d     = len_q;
    pos_d     = pos_q;
    rep_d     = rep_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = len_q[AddrW-1:0];
    rd_addr   = pos_q[AddrW-1:0];
    res_d     = '0;
    res_d.status = ST_OK;

    unique case (kind)
      KIND_START_REC: begin
        if (mode_q != MODE_IDLE) begin
          res_d.status = ST_IGNORED;
        end else begin
          len_d     = '0;
          pos_d     = '0;
          defined_d = 1'b1;
          mode_d    = MODE_RECORDING;
        end
      end
      KIND_END_REC: begin
        if (mode_q == MODE_REPLAYING && rep_q != '0 && len_q != '0) begin
          rep_d = rep_q - CountW'(1);
          pos_d = '0;
        end else if (mode_q != MODE_IDLE) begin
          mode_d = MODE_IDLE;
          rep_d  = '0;
        end
      end
      KIND_EXECUTE: begin
        if (mode_q != MODE_IDLE) begin
          res_d.status = ST_IN_MACRO;
        end else if (!defined_q) begin
          res_d.status = ST_NO_MACRO;
        end else if (count != '0 && len_q != '0) begin
          rep_d  = count - CountW'(1);
          pos_d  = '0;
          mode_d = MODE_REPLAYING;
        end
      end
      KIND_ABORT: begin
        if (mode_q != MODE_IDLE) begin
          mode_d = MODE_IDLE;
          rep_d  = '0;
        end
      end
      KIND_GET_KEY: begin
        // end of macro: wrap while repeats remain, else drop out of replay
        if (mode_q == MODE_REPLAYING && pos_q >= len_q) begin
          if (rep_q != '0 && len_q != '0) begin
            rep_d = rep_q - CountW'(1);
            pos_d = '0;
          end else begin
            mode_d = MODE_IDLE;
            rep_d  = '0;
          end
        end
        res_d.key_valid = 1'b1;
        if (mode_d == MODE_REPLAYING) begin
          rd_en         = 1'b1;
          rd_addr       = pos_d[AddrW-1:0];
          pos_d         = pos_d + LenW'(1);
          res_d.sel_mem = 1'b1;
        end else begin
          res_d.key      = ukey;
          res_d.key_used = 1'b1;
          if (mode_q == MODE_RECORDING) begin
            if (len_q < DepthVal) begin
              wr_en = 1'b1;
              len_d = len_q + LenW'(1);
            end else begin
              res_d.status = ST_FULL;
            end
          end
        end
      end
      KIND_QUERY: begin
        res_d.pending = (mode_q == MODE_REPLAYING) && ((pos_q < len_q) || (rep_q != '0));
      end
      default: begin
      end
    endcase

    res_d.recording = (mode_d == MODE_RECORDING);
    res_d.replaying = (mode_d == MODE_REPLAYING);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      defined_q <= 1'b0;
      len_q     <= '0;
      pos_q     <= '0;
      rep_q     <= '0;
    end else if (in_xfer) begin
      mode_q    <= mode_d;
      defined_q <= defined_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      rep_q     <= rep_d;
    end
  end

  // key store: one write or one read per item, read data held while stalled
  always_ff @(posedge clk_i) begin
    if (in_xfer && wr_en) begin
      mem_q[wr_addr] <= ukey;
    end
    if (in_xfer && rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // middle stage waits for the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= res_d;
    end
  end

  assign s1_key = s1_q.sel_mem ? rd_data_q : s1_q.key;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (!m_valid_q || m_axis_tready_i) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= {s1_q.status, s1_q.replaying, s1_q.recording, s1_q.pending,
                   s1_q.key_used, s1_q.key_valid, s1_key};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

### design/kmrr_checker.sv
// kmrr_checker: port-level checks for the key macro record/replay core
// bound to key_macro_record_replay_core; depends on kmrr_pkg
module kmrr_checker
  import kmrr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[11] && m_axis_tdata_o[12]))
    else $error("recording and replaying both set");

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[9] |-> m_axis_tdata_o[8] && !m_axis_tdata_o[12])
    else $error("user key used without a delivered key or during replay");

  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[10] |-> m_axis_tdata_o[12] && !m_axis_tdata_o[8])
    else $error("pending reported outside replay");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[15:13] == ST_FULL |->
      m_axis_tdata_o[11] && m_axis_tdata_o[9])
    else $error("store full outside a recorded key");

endmodule

bind key_macro_record_replay_core kmrr_checker u_kmrr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### test/testbench.sv
// testbench: self-checking stream test of key_macro_record_replay_core
// predicts every result from its own macro state model and checks results in order
// depends on kmrr_pkg and key_macro_record_replay_core
`timescale 1ns / 1ps

module testbench;
  import kmrr_pkg::*;

  localparam int unsigned KeyStoreDepth = 256;
  localparam int unsigned IdleLimit     = 4000;
  localparam int unsigned MaxReports    = 10;

  // kinds the block treats as no operation
  localparam logic [KindW-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KindW-1:0] KIND_SPARE_7 = 3'd7;

  // one result, laid out like m_axis_tdata_o
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               replaying;
    logic               recording;
    logic               pending;
    logic               key_used;
    logic               key_valid;
    logic [KeyW-1:0]    key;
  } key_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic [KindW-1:0]    s_kind = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  key_macro_record_replay_core #(
    .STORE_DEPTH(KeyStoreDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_kind),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always #1 clk_i = ~clk_i;

  // macro state as the block should hold it
  logic [ModeW-1:0]  macro_mode = MODE_IDLE;
  logic              macro_defined = 1'b0;
  logic [KeyW-1:0]   macro_keys [KeyStoreDepth];
  logic [8:0]        macro_length = '0;
  logic [8:0]        replay_pos = '0;
  logic [CountW-1:0] repeats_left = '0;

  key_result_t results_due [$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold_cycles = 0;
  int          rx_stall_left = 0;
  int          idle_cycles = 0;

  function automatic key_result_t macro_next_result(input logic [KindW-1:0] kind,
                                                    input logic [KeyW-1:0] ukey,
                                                    input logic [CountW-1:0] count);
    key_result_t r;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_START_REC: begin
        if (macro_mode != MODE_IDLE) begin
          r.status = ST_IGNORED;
        end else begin
          macro_length = '0;
          replay_pos = '0;
          macro_defined = 1'b1;
          macro_mode = MODE_RECORDING;
        end
      end
      KIND_END_REC: begin
        // end during replay restarts the macro while repeats remain
        if (macro_mode == MODE_REPLAYING && repeats_left > 0 && macro_length > 0) begin
          repeats_left = repeats_left - 1'b1;
          replay_pos = '0;
        end else if (macro_mode != MODE_IDLE) begin
          macro_mode = MODE_IDLE;
          repeats_left = '0;
        end
      end
      KIND_EXECUTE: begin
        if (macro_mode != MODE_IDLE) begin
          r.status = ST_IN_MACRO;
        end else if (!macro_defined) begin
          r.status = ST_NO_MACRO;
        end else if (count > 0 && macro_length > 0) begin
          repeats_left = count - 1'b1;
          replay_pos = '0;
          macro_mode = MODE_REPLAYING;
        end
      end
      KIND_ABORT: begin
        if (macro_mode != MODE_IDLE) begin
          macro_mode = MODE_IDLE;
          repeats_left = '0;
        end
      end
      KIND_GET_KEY: begin
        if (macro_mode == MODE_REPLAYING && replay_pos >= macro_length) begin
          if (repeats_left > 0 && macro_length > 0) begin
            repeats_left = repeats_left - 1'b1;
            replay_pos = '0;
          end else begin
            macro_mode = MODE_IDLE;
            repeats_left = '0;
          end
        end
        r.key_valid = 1'b1;
        if (macro_mode == MODE_REPLAYING) begin
          r.key = macro_keys[replay_pos[7:0]];
          replay_pos = replay_pos + 1'b1;
        end else begin
          r.key = ukey;
          r.key_used = 1'b1;
          if (macro_mode == MODE_RECORDING) begin
            if (macro_length < KeyStoreDepth) begin
              macro_keys[macro_length[7:0]] = ukey;
              macro_length = macro_length + 1'b1;
            end else begin
              r.status = ST_FULL;
            end
          end
        end
      end
      KIND_QUERY: begin
        r.pending = (macro_mode == MODE_REPLAYING) &&
                    (replay_pos < macro_length || repeats_left > 0);
      end
      default: ;
    endcase
    r.recording = (macro_mode == MODE_RECORDING);
    r.replaying = (macro_mode == MODE_REPLAYING);
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return KeyW'($urandom_range(0, 255));
  endfunction

  function automatic logic [CountW-1:0] rand_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return CountW'($urandom_range(0, 4));
    if (r < 9) return CountW'($urandom_range(5, 20));
    return CountW'($urandom_range(0, 65535));
  endfunction

  task automatic send_op(input logic [KindW-1:0] kind, input logic [KeyW-1:0] ukey,
                         input logic [CountW-1:0] count);
    int gap;
    gap = tx_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_kind  <= kind;
    s_data  <= {count, ukey};
    do @(posedge clk_i); while (!s_ready);
    results_due.push_back(macro_next_result(kind, ukey, count));
    items_sent++;
  endtask

  // sender pauses until every result is back
  task automatic wait_results_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  task automatic test_directed_modes();
    send_op(KIND_QUERY, 8'h00, 16'h0000);
    send_op(KIND_END_REC, 8'hFF, 16'hFFFF);
    send_op(KIND_ABORT, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd3);     // never recorded
    send_op(KIND_GET_KEY, 8'h00, 16'h0000);
    send_op(KIND_GET_KEY, 8'hFF, 16'hFFFF);
    send_op(KIND_SPARE_6, 8'hFF, 16'hFFFF);
    send_op(KIND_SPARE_7, 8'h55, 16'hAAAA);
    send_op(KIND_START_REC, 8'h00, 16'h0000);
    send_op(KIND_START_REC, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd1);
    send_op(KIND_GET_KEY, 8'h00, 16'h0000);
    send_op(KIND_GET_KEY, 8'hFF, 16'h0000);
    send_op(KIND_GET_KEY, 8'h5A, 16'h0000);
    send_op(KIND_QUERY, 8'h00, 16'h0000);
    send_op(KIND_END_REC, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd0);     // zero count does nothing
    send_op(KIND_EXECUTE, 8'h00, 16'd2);
    send_op(KIND_START_REC, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd2);
    send_op(KIND_QUERY, 8'h00, 16'h0000);
    repeat (7) send_op(KIND_GET_KEY, rand_key(), 16'h0000);  // wraps, then runs out
    send_op(KIND_QUERY, 8'h00, 16'h0000);
  endtask

  task automatic test_replay_edges();
    send_op(KIND_EXECUTE, 8'h00, 16'hFFFF);
    send_op(KIND_GET_KEY, 8'h11, 16'h0000);
    send_op(KIND_GET_KEY, 8'h22, 16'h0000);
    send_op(KIND_END_REC, 8'h00, 16'h0000);  // restart with repeats left
    send_op(KIND_GET_KEY, 8'h33, 16'h0000);
    send_op(KIND_ABORT, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd1);
    repeat (3) send_op(KIND_GET_KEY, rand_key(), 16'h0000);
    send_op(KIND_QUERY, 8'h00, 16'h0000);
    send_op(KIND_END_REC, 8'h00, 16'h0000);  // no repeats left ends replay
    // empty macro never starts a replay
    send_op(KIND_START_REC, 8'h00, 16'h0000);
    send_op(KIND_END_REC, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd4);
    send_op(KIND_GET_KEY, 8'h77, 16'h0000);
    // abort closes a recording
    send_op(KIND_START_REC, 8'h00, 16'h0000);
    send_op(KIND_GET_KEY, 8'h80, 16'h0000);
    send_op(KIND_ABORT, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd2);
    repeat (3) send_op(KIND_GET_KEY, rand_key(), 16'h0000);
  endtask

  task automatic test_store_full();
    send_op(KIND_START_REC, 8'h00, 16'h0000);
    repeat (KeyStoreDepth + 3) send_op(KIND_GET_KEY, rand_key(), rand_count());
    send_op(KIND_QUERY, 8'h00, 16'h0000);
    send_op(KIND_END_REC, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd1);
    repeat (KeyStoreDepth + 2) send_op(KIND_GET_KEY, rand_key(), 16'h0000);
  endtask

  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_cycles = 400;
    send_op(KIND_START_REC, 8'h00, 16'h0000);
    repeat (6) send_op(KIND_GET_KEY, rand_key(), 16'h0000);
    send_op(KIND_END_REC, 8'h00, 16'h0000);
    send_op(KIND_EXECUTE, 8'h00, 16'd3);
    repeat (20) send_op(KIND_GET_KEY, rand_key(), 16'h0000);
    send_op(KIND_QUERY, 8'h00, 16'h0000);
    wait_results_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_sessions();
    int first;
    int n;
    int pick;
    first = items_sent;
    while (items_sent - first < 200) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_op(KIND_START_REC, rand_key(), rand_count());
        n = $urandom_range(0, 12);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) send_op(KIND_QUERY, rand_key(), rand_count());
          else send_op(KIND_GET_KEY, rand_key(), rand_count());
        end
        if ($urandom_range(0, 3) == 0) send_op(KIND_ABORT, rand_key(), rand_count());
        else send_op(KIND_END_REC, rand_key(), rand_count());
      end else if (pick < 8) begin
        send_op(KIND_EXECUTE, rand_key(), rand_count());
        n = $urandom_range(0, 30);
        repeat (n) begin
          case ($urandom_range(0, 19))
            0: send_op(KIND_END_REC, rand_key(), rand_count());
            1: send_op(KIND_ABORT, rand_key(), rand_count());
            2: send_op(KIND_START_REC, rand_key(), rand_count());
            3: send_op(KIND_EXECUTE, rand_key(), rand_count());
            4, 5: send_op(KIND_QUERY, rand_key(), rand_count());
            default: send_op(KIND_GET_KEY, rand_key(), rand_count());
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_op(KindW'($urandom_range(0, 7)), rand_key(), rand_count());
      end
    end
  endtask

  // result side: random stalls, requested hold-off, in-order check
  always @(posedge clk_i) begin
    key_result_t got;
    key_result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got = m_data;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result transfer: %h", m_data);
        end else begin
          want = results_due.pop_front();
          if (got.key !== want.key || got.key_valid !== want.key_valid ||
              got.key_used !== want.key_used || got.pending !== want.pending ||
              got.recording !== want.recording || got.replaying !== want.replaying ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display({"result mismatch: exp key=%h kv=%b used=%b pend=%b rec=%b rep=%b",
                        " st=%0d, got key=%h kv=%b used=%b pend=%b rec=%b rep=%b st=%0d"},
                       want.key, want.key_valid, want.key_used, want.pending,
                       want.recording, want.replaying, want.status,
                       got.key, got.key_valid, got.key_used, got.pending,
                       got.recording, got.replaying, got.status);
          end
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        rx_stall_left = gap_len();
        m_ready <= (rx_stall_left == 0);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("key_macro_record_replay_core regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_modes();
    test_replay_edges();
    wait_results_drained();
    test_store_full();
    test_output_backpressure();
    test_random_sessions();
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("key_macro_record_replay_core regression: pass");
    end else begin
      $display("key_macro_record_replay_core regression: fail");
    end
    $finish;
  end

endmodule
